// ----- rtl/fpack_pkg.sv -----
// Package for the float pack block: format codes, status codes and widths.
package fpack_pkg;

  localparam int unsigned ExpW   = 16;
  localparam int unsigned MantHw = 16;
  localparam int unsigned MantLw = 64;
  localparam int unsigned MantW  = MantHw + MantLw;
  localparam int unsigned PackLw = 64;
  localparam int unsigned PackHw = 16;

  localparam logic [ExpW-1:0] IntBias = 16'h7FFF;
  localparam logic [ExpW-1:0] IntInf  = 16'hFFFF;

  localparam logic [1:0] FmtSingle   = 2'd0;
  localparam logic [1:0] FmtDouble   = 2'd1;
  localparam logic [1:0] FmtExtended = 2'd2;
  localparam logic [1:0] FmtUnknown  = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StUnder = 2'd1;
  localparam logic [1:0] StOver  = 2'd2;
  localparam logic [1:0] StError = 2'd3;

  typedef struct packed {
    logic [PackLw-1:0] packed_low;
    logic [PackHw-1:0] packed_high;
    logic [1:0]        status;
  } result_t;

endpackage

// ----- rtl/fpack_core.sv -----
// Combinational pack, round and rebias of one internal float.
module fpack_core (
  input  logic                          sign_bit_i,
  input  logic [fpack_pkg::ExpW-1:0]    biased_exponent_i,
  input  logic [fpack_pkg::MantHw-1:0]  mantissa_high_i,
  input  logic [fpack_pkg::MantLw-1:0]  mantissa_low_i,
  input  logic                          is_exact_zero_i,
  input  logic [1:0]                    target_format_i,
  output fpack_pkg::result_t            result_o
);

  logic [fpack_pkg::MantW-1:0] mant;
  logic [63:0] field, fmask;
  logic        rbit;
  logic [64:0] inc;
  logic        carry;
  logic [16:0] exp_c;
  logic        over_c;
  logic [17:0] exp_r;
  logic [14:0] einf;
  logic [15:0] bias_adj;
  logic        over, under;
  logic [14:0] exp_f;
  logic [63:0] field_f;

  assign mant = {mantissa_high_i, mantissa_low_i};

  always_comb begin
    field    = '0;
    fmask    = '0;
    rbit     = 1'b0;
    einf     = '0;
    bias_adj = '0;
    unique case (target_format_i)
      fpack_pkg::FmtSingle: begin
        field    = {41'd0, mant[78:56]};
        fmask    = {41'd0, {23{1'b1}}};
        rbit     = mant[55];
        einf     = 15'h00FF;
        bias_adj = 16'd32640;
      end
      fpack_pkg::FmtDouble: begin
        field    = {12'd0, mant[78:27]};
        fmask    = {12'd0, {52{1'b1}}};
        rbit     = mant[26];
        einf     = 15'h07FF;
        bias_adj = 16'd31744;
      end
      fpack_pkg::FmtExtended: begin
        field    = mant[79:16];
        fmask    = '1;
        rbit     = mant[15];
        einf     = 15'h7FFF;
        bias_adj = 16'd16384;
      end
      default: ;
    endcase

    inc    = {1'b0, field} + 65'(rbit);
    carry  = rbit && (field == fmask);
    exp_c  = {1'b0, biased_exponent_i};
    over_c = 1'b0;
    if (carry) begin
      if (biased_exponent_i >= 16'hFFFE) over_c = 1'b1;
      else exp_c = exp_c + 17'd1;
    end
    exp_r = {1'b0, exp_c} - {2'b00, bias_adj};
    // carry leaves an all-zero fraction; extended keeps its explicit one
    if (carry) begin
      field_f = (target_format_i == fpack_pkg::FmtExtended) ? 64'h8000_0000_0000_0000 : '0;
    end else begin
      field_f = inc[63:0] & fmask;
    end
    over  = over_c || (!exp_r[17] && exp_r[16:0] >= {2'b00, einf});
    under = !over && (exp_r[17] || exp_r == '0);
    exp_f = exp_r[14:0];
    if (under) begin
      field_f = '0;
      exp_f   = '0;
    end else if (over) begin
      field_f = '0;
      exp_f   = einf;
    end

    result_o = '0;
    unique case (target_format_i)
      fpack_pkg::FmtSingle:
        result_o.packed_low = {32'd0, sign_bit_i, exp_f[7:0], field_f[22:0]};
      fpack_pkg::FmtDouble:
        result_o.packed_low = {sign_bit_i, exp_f[10:0], field_f[51:0]};
      fpack_pkg::FmtExtended: begin
        result_o.packed_low  = field_f;
        result_o.packed_high = {sign_bit_i, exp_f};
      end
      default: ;
    endcase
    if (target_format_i == fpack_pkg::FmtUnknown) result_o.status = fpack_pkg::StError;
    else if (over) result_o.status = fpack_pkg::StOver;
    else if (under) result_o.status = is_exact_zero_i ? fpack_pkg::StOk : fpack_pkg::StUnder;
    else result_o.status = fpack_pkg::StOk;
  end

endmodule

// ----- rtl/float_pack_to_ieee_format.sv -----
// Top level of the float pack block: input register, pack logic, result register.
// Packs an internal float (sign, 16-bit exponent bias 32767, 80-bit mantissa
// with explicit leading one) into IEEE single, double or 80-bit extended.
// Input channel: in_valid_i / in_stall_o; an item is taken when valid is high
// and stall is low. Output channel: out_valid_o / out_stall_i likewise.
// An item taken sits in the input register; its result is then loaded into
// the result register, where it is shown. Throughput: one item per cycle
// while the receiver does not stall; the pack logic is a single pass
// between the two registers.
// When the receiver stalls, the result register holds its item and the input
// register fills; further items are then stalled, no item is lost.
// Reset clears both valid flags; no item is held after reset.
// Status: 0 ok, 1 underflow, 2 overflow, 3 error (unknown format).
module float_pack_to_ieee_format (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          sign_bit_i,
  input  logic [fpack_pkg::ExpW-1:0]    biased_exponent_i,
  input  logic [fpack_pkg::MantHw-1:0]  mantissa_high_i,
  input  logic [fpack_pkg::MantLw-1:0]  mantissa_low_i,
  input  logic                          is_exact_zero_i,
  input  logic [1:0]                    target_format_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fpack_pkg::PackLw-1:0]  packed_low_o,
  output logic [fpack_pkg::PackHw-1:0]  packed_high_o,
  output logic [1:0]                    status_o
);

  logic                         s_valid_q;
  logic                         sign_q, zero_q;
  logic [fpack_pkg::ExpW-1:0]   exp_q;
  logic [fpack_pkg::MantHw-1:0] mh_q;
  logic [fpack_pkg::MantLw-1:0] ml_q;
  logic [1:0]                   fmt_q;
  logic                         r_valid_q;
  fpack_pkg::result_t           res_d, res_q;
  logic                         r_load, s_load;

  assign r_load     = s_valid_q && (!r_valid_q || !out_stall_i);
  assign in_stall_o = s_valid_q && !r_load;
  assign s_load     = in_valid_i && !in_stall_o;

  fpack_core u_core (
    .sign_bit_i        (sign_q),
    .biased_exponent_i (exp_q),
    .mantissa_high_i   (mh_q),
    .mantissa_low_i    (ml_q),
    .is_exact_zero_i   (zero_q),
    .target_format_i   (fmt_q),
    .result_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
    end else begin
      if (s_load) s_valid_q <= 1'b1;
      else if (r_load) s_valid_q <= 1'b0;
      if (r_load) r_valid_q <= 1'b1;
      else if (!out_stall_i) r_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_load) begin
      sign_q <= sign_bit_i;
      exp_q  <= biased_exponent_i;
      mh_q   <= mantissa_high_i;
      ml_q   <= mantissa_low_i;
      zero_q <= is_exact_zero_i;
      fmt_q  <= target_format_i;
    end
    if (r_load) res_q <= res_d;
  end

  assign out_valid_o   = r_valid_q;
  assign packed_low_o  = res_q.packed_low;
  assign packed_high_o = res_q.packed_high;
  assign status_o      = res_q.status;

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s_valid_q && r_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(res_q)))
    else $error("stalled result changed");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_q && !in_stall_o) |=> out_valid_o)
    else $error("item lost between stages");

endmodule
